// ===== src/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

  // Command codes carried by in_command
  localparam logic [1:0] CMD_ADVANCE = 2'd0;
  localparam logic [1:0] CMD_PAUSE   = 2'd1;
  localparam logic [1:0] CMD_RESUME  = 2'd2;

  // Duck ramp constants
  localparam int unsigned DUCK_NUM   = 47;
  localparam int unsigned DUCK_SHIFT = 7;
  localparam logic [7:0]  RISE_STEP  = 8'd3;
  localparam logic [7:0]  FALL_STEP  = 8'd18;

  localparam logic [6:0]  DIP_RESET   = 7'd127;
  localparam logic [7:0]  DEPTH_LIMIT = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORE,
    ST_FAST,
    ST_SLOW,
    ST_FINISH
  } tts_state_t;

  // Duck target: music volume, or 47/128 of it while voice is active
  function automatic logic [6:0] duck_target(input logic [6:0] music, input logic voice);
    logic [12:0] prod;
    prod = 13'(DUCK_NUM) * {6'd0, music};
    return voice ? {1'b0, prod[12:DUCK_SHIFT]} : music;
  endfunction

  // One ramp step toward the target, never passing it
  function automatic logic [6:0] duck_step(input logic [6:0] cur, input logic [6:0] target);
    logic [7:0] up;
    logic [7:0] lim;
    up  = {1'b0, cur} + RISE_STEP;
    lim = {1'b0, target} + FALL_STEP;
    if (cur < target) begin
      return (up >= {1'b0, target}) ? target : up[6:0];
    end else if (cur > target) begin
      return ({1'b0, cur} <= lim) ? target : 7'({1'b0, cur} - FALL_STEP);
    end
    return cur;
  endfunction

endpackage

`default_nettype wire

// ===== src/tts_step_unit.sv =====
`default_nettype none

// Shared compare-and-subtract: tells whether a period fits and what is left.
module tts_step_unit #(
  parameter int W = 21
) (
  input  wire logic [W-1:0] acc,
  input  wire logic [W-1:0] period,
  output logic              fits,
  output logic [W-1:0]      rest
);

  logic [W:0] diff;

  assign diff = {1'b0, acc} - {1'b0, period};
  assign fits = ~diff[W];
  assign rest = diff[W-1:0];

endmodule

`default_nettype wire

// ===== src/tiered_tick_scheduler_with_duck_ramp.sv =====
`default_nettype none

// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+------------------------------------------
// in_      | in        | in_valid / in_stall  | command, elapsed_us, music_volume, voice
// out_     | out       | out_valid / out_stall| tick counts, dipped volume, depth, notifies
//
// Flow: an item is taken only in idle. Pause, resume, unknown commands and
//   ignored advances go straight to the finish step. An advance steps the core
//   tier and, when not paused and a service tick fired, then the fast and slow
//   tiers; the one shared compare-and-subtract unit retires one tick per cycle.
// Reset: synchronous, active low; accumulators clear, dipped level goes to 127.
// Stalls: a finished word sits in the output register; a new item is taken
//   while it waits, and its own result holds in the finish step until the slot frees.
module tiered_tick_scheduler_with_duck_ramp #(
  parameter int SERVICE_PERIOD_US = 10000,
  parameter int LOGICAL_TICK_US   = 10000,
  parameter int FAST_PERIOD_US    = 16667,
  parameter int SLOW_PERIOD_US    = 100000,
  parameter int MAX_CATCHUP       = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_elapsed_us,
  input  wire logic [6:0]         in_music_volume,
  input  wire logic               in_voice_active,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              out_core_ticks,
  output logic [3:0]              out_fast_ticks,
  output logic [2:0]              out_slow_ticks,
  output logic [6:0]              out_dipped_volume,
  output logic [7:0]              out_pause_depth,
  output logic                    out_notify_pause,
  output logic                    out_notify_resume
);

  import tts_pkg::*;

  // Worst-case accumulator values set the datapath width
  localparam int CAP      = SERVICE_PERIOD_US * MAX_CATCHUP;
  localparam int CORE_MAX = SERVICE_PERIOD_US - 1 + CAP;
  localparam int LOG_MAX  = LOGICAL_TICK_US * MAX_CATCHUP;
  localparam int FAST_MAX = FAST_PERIOD_US - 1 + LOG_MAX;
  localparam int SLOW_MAX = SLOW_PERIOD_US - 1 + LOG_MAX;
  localparam int TOP_A    = (CORE_MAX > FAST_MAX) ? CORE_MAX : FAST_MAX;
  localparam int TOP_MAX  = (TOP_A > SLOW_MAX) ? TOP_A : SLOW_MAX;
  localparam int W        = $clog2(TOP_MAX + 1);
  localparam int LW       = $clog2(LOG_MAX + 1);

  tts_state_t state_r, state_nxt;

  logic [W-1:0]  core_acc_r, core_acc_nxt;
  logic [W-1:0]  fast_acc_r, fast_acc_nxt;
  logic [W-1:0]  slow_acc_r, slow_acc_nxt;
  logic [LW-1:0] logical_r, logical_nxt;
  logic [6:0]    dip_r, dip_nxt;
  logic [7:0]    depth_r, depth_nxt;
  logic [6:0]    target_r, target_nxt;
  logic [3:0]    core_n_r, core_n_nxt;
  logic [3:0]    fast_n_r, fast_n_nxt;
  logic [2:0]    slow_n_r, slow_n_nxt;
  logic          np_r, np_nxt;
  logic          nr_r, nr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_core_r, out_core_nxt;
  logic [3:0]    out_fast_r, out_fast_nxt;
  logic [2:0]    out_slow_r, out_slow_nxt;
  logic [6:0]    out_dip_r, out_dip_nxt;
  logic [7:0]    out_depth_r, out_depth_nxt;
  logic          out_np_r, out_np_nxt;
  logic          out_nr_r, out_nr_nxt;

  logic          in_take;
  logic          elapsed_ok;
  logic [W-1:0]  elapsed_cl;
  logic [W-1:0]  unit_acc, unit_period, unit_rest;
  logic          unit_fits;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Drop zero and negative values, clamp to the catch-up cap
  assign elapsed_ok = (in_elapsed_us > 32'sd0);
  assign elapsed_cl = (in_elapsed_us > $signed(32'(CAP))) ? W'(CAP) : in_elapsed_us[W-1:0];

  // Route the active tier to the shared unit
  always_comb begin
    case (state_r)
      ST_FAST: begin
        unit_acc    = fast_acc_r;
        unit_period = W'(FAST_PERIOD_US);
      end
      ST_SLOW: begin
        unit_acc    = slow_acc_r;
        unit_period = W'(SLOW_PERIOD_US);
      end
      default: begin
        unit_acc    = core_acc_r;
        unit_period = W'(SERVICE_PERIOD_US);
      end
    endcase
  end

  tts_step_unit #(.W(W)) u_step (
    .acc    (unit_acc),
    .period (unit_period),
    .fits   (unit_fits),
    .rest   (unit_rest)
  );

  always_comb begin
    state_nxt     = state_r;
    core_acc_nxt  = core_acc_r;
    fast_acc_nxt  = fast_acc_r;
    slow_acc_nxt  = slow_acc_r;
    logical_nxt   = logical_r;
    dip_nxt       = dip_r;
    depth_nxt     = depth_r;
    target_nxt    = target_r;
    core_n_nxt    = core_n_r;
    fast_n_nxt    = fast_n_r;
    slow_n_nxt    = slow_n_r;
    np_nxt        = np_r;
    nr_nxt        = nr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_core_nxt  = out_core_r;
    out_fast_nxt  = out_fast_r;
    out_slow_nxt  = out_slow_r;
    out_dip_nxt   = out_dip_r;
    out_depth_nxt = out_depth_r;
    out_np_nxt    = out_np_r;
    out_nr_nxt    = out_nr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          core_n_nxt  = '0;
          fast_n_nxt  = '0;
          slow_n_nxt  = '0;
          np_nxt      = 1'b0;
          nr_nxt      = 1'b0;
          logical_nxt = '0;
          target_nxt  = duck_target(in_music_volume, in_voice_active);
          state_nxt   = ST_FINISH;
          case (in_command)
            CMD_ADVANCE: begin
              if (elapsed_ok) begin
                core_acc_nxt = core_acc_r + elapsed_cl;
                state_nxt    = ST_CORE;
              end
            end
            CMD_PAUSE: begin
              if (depth_r != DEPTH_LIMIT) begin
                np_nxt    = (depth_r == 8'd0);
                depth_nxt = depth_r + 8'd1;
              end
            end
            CMD_RESUME: begin
              nr_nxt = (depth_r == 8'd1);
              if (depth_r != 8'd0) begin
                depth_nxt = depth_r - 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CORE: begin
        if (unit_fits) begin
          core_acc_nxt = unit_rest;
          core_n_nxt   = core_n_r + 4'd1;
          logical_nxt  = logical_r + LW'(LOGICAL_TICK_US);
        end else if (depth_r == 8'd0 && logical_r != '0) begin
          // Feed logical time into both tiers
          fast_acc_nxt = fast_acc_r + W'(logical_r);
          slow_acc_nxt = slow_acc_r + W'(logical_r);
          state_nxt    = ST_FAST;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FAST: begin
        if (unit_fits) begin
          fast_acc_nxt = unit_rest;
          fast_n_nxt   = fast_n_r + 4'd1;
        end else begin
          state_nxt = ST_SLOW;
        end
      end
      ST_SLOW: begin
        if (unit_fits) begin
          slow_acc_nxt = unit_rest;
          slow_n_nxt   = slow_n_r + 3'd1;
          dip_nxt      = duck_step(dip_r, target_r);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Load the output register once the previous word is gone
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_core_nxt  = core_n_r;
          out_fast_nxt  = fast_n_r;
          out_slow_nxt  = slow_n_r;
          out_dip_nxt   = dip_r;
          out_depth_nxt = depth_r;
          out_np_nxt    = np_r;
          out_nr_nxt    = nr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      core_acc_r  <= '0;
      fast_acc_r  <= '0;
      slow_acc_r  <= '0;
      dip_r       <= DIP_RESET;
      depth_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      core_acc_r  <= core_acc_nxt;
      fast_acc_r  <= fast_acc_nxt;
      slow_acc_r  <= slow_acc_nxt;
      dip_r       <= dip_nxt;
      depth_r     <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logical_r   <= logical_nxt;
    target_r    <= target_nxt;
    core_n_r    <= core_n_nxt;
    fast_n_r    <= fast_n_nxt;
    slow_n_r    <= slow_n_nxt;
    np_r        <= np_nxt;
    nr_r        <= nr_nxt;
    out_core_r  <= out_core_nxt;
    out_fast_r  <= out_fast_nxt;
    out_slow_r  <= out_slow_nxt;
    out_dip_r   <= out_dip_nxt;
    out_depth_r <= out_depth_nxt;
    out_np_r    <= out_np_nxt;
    out_nr_r    <= out_nr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_core_ticks    = out_core_r;
  assign out_fast_ticks    = out_fast_r;
  assign out_slow_ticks    = out_slow_r;
  assign out_dipped_volume = out_dip_r;
  assign out_pause_depth   = out_depth_r;
  assign out_notify_pause  = out_np_r;
  assign out_notify_resume = out_nr_r;

endmodule

`default_nettype wire

// ===== src/tts_checker.sv =====
`default_nettype none

module tts_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [3:0]         out_core_ticks,
  input wire logic [3:0]         out_fast_ticks,
  input wire logic [2:0]         out_slow_ticks,
  input wire logic [6:0]         out_dipped_volume,
  input wire logic [7:0]         out_pause_depth,
  input wire logic               out_notify_pause,
  input wire logic               out_notify_resume
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pause_depth)
      && $stable(out_dipped_volume) && $stable(out_core_ticks))
    else $error("stalled output word changed");

  // First pause lands on depth one
  a_pause_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify_pause |-> out_pause_depth == 8'd1 && !out_notify_resume)
    else $error("pause notify with wrong depth");

  // Last resume lands on depth zero
  a_resume_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify_resume |-> out_pause_depth == 8'd0)
    else $error("resume notify with wrong depth");

  // Notifies come only from pause or resume, which fire no ticks
  a_notify_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_notify_pause || out_notify_resume) |->
      out_core_ticks == 4'd0 && out_fast_ticks == 4'd0 && out_slow_ticks == 3'd0)
    else $error("ticks reported with a notify");

endmodule

bind tiered_tick_scheduler_with_duck_ramp tts_checker u_tts_checker (.*);

`default_nettype wire
